### sv/assert_macros.svh
// Assertion macros used by the rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

### sv/fblr_pkg.sv
// Types, command codes and controller states of the line rasterizer.
`default_nettype none

package fblr_pkg;

  // Coordinate, delta and decision-variable types
  typedef logic signed [10:0] coord_t;
  typedef logic        [11:0] delta_t;
  typedef logic signed [13:0] dec_t;

  // Command codes
  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Controller states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_CLEAR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### sv/fblr_req_if.sv
// Request channel of the line rasterizer: command and coordinates.
`default_nettype none

interface fblr_req_if;
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  fblr_pkg::coord_t    start_x;
  fblr_pkg::coord_t    start_y;
  fblr_pkg::coord_t    end_x;
  fblr_pkg::coord_t    end_y;
  logic                color;

  modport source (output valid, cmd, start_x, start_y, end_x, end_y, color, input ready);
  modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, color, output ready);
endinterface

`default_nettype wire

### sv/fblr_res_if.sv
// Result channel of the line rasterizer: pixel color and frame hit.
`default_nettype none

interface fblr_res_if;
  logic valid;
  logic ready;
  logic pixel_color;
  logic on_frame;

  modport source (output valid, pixel_color, on_frame, input ready);
  modport sink   (input valid, pixel_color, on_frame, output ready);
endinterface

`default_nettype wire

### sv/framebuffer_line_rasterizer_unit.sv
// Monochrome frame store with line draw, pixel read and clear commands.
`default_nettype none
`include "assert_macros.svh"

// The frame lives in one synchronous RAM of FB_HEIGHT rows, FB_WIDTH pixels per
// row (bit x of a row is pixel x, 1 = black). Every request returns exactly one
// result. A line walks one pixel per cycle along its major axis, after a setup
// state and before a drain and a reply state. Each pixel is a read-modify-write
// of its row through the registered RAM read; back-to-back hits on the same row
// are forwarded from the last write. A pixel read passes an address and a data
// state. A clear writes one row per cycle. After reset the block sweeps all
// FB_HEIGHT rows to black before it takes its first request. A new request is
// taken as soon as the previous one has finished, even while its result still
// waits in the output register.
module framebuffer_line_rasterizer_unit #(
  parameter int FB_WIDTH  = 32,
  parameter int FB_HEIGHT = 16
) (
  input  wire          clk,
  input  wire          rst,
  fblr_req_if.sink     req,
  fblr_res_if.source   res
);

  localparam int AW = (FB_HEIGHT > 1) ? $clog2(FB_HEIGHT) : 1;
  localparam int XW = $clog2(FB_WIDTH);
  localparam logic [AW-1:0] LAST_ROW = AW'(FB_HEIGHT - 1);
  localparam logic [9:0]    W_LIM    = 10'(FB_WIDTH);
  localparam logic [9:0]    H_LIM    = 10'(FB_HEIGHT);

  fblr_pkg::state_t state, state_next;

  // Latched request and walker registers
  logic [1:0]        cmd;
  logic              color;
  fblr_pkg::coord_t  cx, cy, ex, ey;
  logic              sx_neg, sy_neg, x_major;
  fblr_pkg::dec_t    d, inc_a, inc_b;
  logic [AW-1:0]     clr_row;
  logic              rd_color, rd_on;

  // Pixel write stage
  logic              p_valid;
  logic [AW-1:0]     p_row;
  logic [XW-1:0]     p_col;
  logic              fw_valid;
  logic [AW-1:0]     fw_row;
  logic [FB_WIDTH-1:0] fw_data;

  // Frame RAM
  logic [FB_WIDTH-1:0] mem [FB_HEIGHT];
  logic [FB_WIDTH-1:0] rdata;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [FB_WIDTH-1:0] mem_wdata;

  logic accept, out_free, on_frame_c, walk_last, diag;
  logic [FB_WIDTH-1:0] px_base, px_data, clr_data;

  // Setup terms
  logic signed [11:0] dx_full, dy_full;
  fblr_pkg::delta_t   adx, ady, dmaj, dmin;
  logic               x_major_c;

  // Magnitude of a negative delta
  function automatic fblr_pkg::delta_t delta_t_neg(input logic signed [11:0] v);
    logic signed [11:0] n;
    n = -v;
    return fblr_pkg::delta_t'(n);
  endfunction

  assign accept   = req.valid && req.ready;
  assign out_free = !res.valid || res.ready;
  assign req.ready = (state == fblr_pkg::ST_IDLE);

  // Current point inside the frame
  assign on_frame_c = !cx[10] && !cy[10] && (10'(cx) < W_LIM) && (10'(cy) < H_LIM);

  // Setup arithmetic
  always_comb begin
    dx_full   = {ex[10], ex} - {cx[10], cx};
    dy_full   = {ey[10], ey} - {cy[10], cy};
    adx       = dx_full[11] ? delta_t_neg(dx_full) : fblr_pkg::delta_t'(dx_full);
    ady       = dy_full[11] ? delta_t_neg(dy_full) : fblr_pkg::delta_t'(dy_full);
    x_major_c = (adx >= ady);
    dmaj      = x_major_c ? adx : ady;
    dmin      = x_major_c ? ady : adx;
  end

  // Walk control
  assign walk_last = x_major ? (cx == ex) : (cy == ey);
  assign diag      = (d > 0);

  // Row modify with forwarding from the previous write
  always_comb begin
    px_base = (fw_valid && fw_row == p_row) ? fw_data : rdata;
    px_data = px_base;
    px_data[p_col] = ~color;
    clr_data = (state == fblr_pkg::ST_INIT) ? {FB_WIDTH{1'b1}} : {FB_WIDTH{~color}};
  end

  // RAM port selection
  assign mem_raddr = cy[AW-1:0];
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_row;
    mem_wdata = clr_data;
    if (p_valid) begin
      mem_we    = 1'b1;
      mem_waddr = p_row;
      mem_wdata = px_data;
    end else if (state == fblr_pkg::ST_INIT || state == fblr_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fblr_pkg::ST_INIT: begin
        if (clr_row == LAST_ROW) state_next = fblr_pkg::ST_IDLE;
      end
      fblr_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (req.cmd == fblr_pkg::CMD_DRAW)  state_next = fblr_pkg::ST_SETUP;
          else if (req.cmd == fblr_pkg::CMD_READ)      state_next = fblr_pkg::ST_RD_ADDR;
          else if (req.cmd == fblr_pkg::CMD_CLEAR)     state_next = fblr_pkg::ST_CLEAR;
          else                                         state_next = fblr_pkg::ST_DONE;
        end
      end
      fblr_pkg::ST_SETUP:   state_next = fblr_pkg::ST_WALK;
      fblr_pkg::ST_WALK: begin
        if (walk_last) state_next = fblr_pkg::ST_DRAIN;
      end
      fblr_pkg::ST_DRAIN:   state_next = fblr_pkg::ST_DONE;
      fblr_pkg::ST_RD_ADDR: state_next = fblr_pkg::ST_RD_DATA;
      fblr_pkg::ST_RD_DATA: state_next = fblr_pkg::ST_DONE;
      fblr_pkg::ST_CLEAR: begin
        if (clr_row == LAST_ROW) state_next = fblr_pkg::ST_DONE;
      end
      fblr_pkg::ST_DONE: begin
        if (out_free) state_next = fblr_pkg::ST_IDLE;
      end
      default: state_next = fblr_pkg::ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= fblr_pkg::ST_INIT;
    else     state <= state_next;
  end

  // Clear sweep row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (state == fblr_pkg::ST_INIT || state == fblr_pkg::ST_CLEAR) begin
      clr_row <= (clr_row == LAST_ROW) ? '0 : clr_row + AW'(1);
    end
  end

  // Request latch, walker and read result
  always_ff @(posedge clk) begin
    unique case (state)
      fblr_pkg::ST_IDLE: begin
        if (accept) begin
          cmd      <= req.cmd;
          color    <= req.color;
          cx       <= req.start_x;
          cy       <= req.start_y;
          ex       <= req.end_x;
          ey       <= req.end_y;
          rd_color <= 1'b0;
          rd_on    <= 1'b0;
        end
      end
      fblr_pkg::ST_SETUP: begin
        x_major <= x_major_c;
        sx_neg  <= dx_full[11];
        sy_neg  <= dy_full[11];
        d       <= $signed({1'b0, dmin, 1'b0}) - $signed({2'b00, dmaj});
        inc_a   <= $signed({1'b0, dmin, 1'b0});
        inc_b   <= $signed({1'b0, dmin, 1'b0}) - $signed({1'b0, dmaj, 1'b0});
      end
      fblr_pkg::ST_WALK: begin
        if (!walk_last) begin
          d <= diag ? d + inc_b : d + inc_a;
          if (x_major || diag) cx <= sx_neg ? cx - 11'sd1 : cx + 11'sd1;
          if (!x_major || diag) cy <= sy_neg ? cy - 11'sd1 : cy + 11'sd1;
        end
      end
      fblr_pkg::ST_RD_DATA: begin
        rd_on    <= on_frame_c;
        rd_color <= on_frame_c && !rdata[cx[XW-1:0]];
      end
      default: begin
      end
    endcase
  end

  // Pixel write stage and forwarding register
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      fw_valid <= 1'b0;
    end else begin
      p_valid  <= (state == fblr_pkg::ST_WALK) && on_frame_c;
      fw_valid <= p_valid;
    end
    p_row   <= cy[AW-1:0];
    p_col   <= cx[XW-1:0];
    fw_row  <= p_row;
    fw_data <= px_data;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == fblr_pkg::ST_DONE && out_free) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (state == fblr_pkg::ST_DONE && out_free) begin
      res.pixel_color <= (cmd == fblr_pkg::CMD_READ) && rd_color;
      res.on_frame    <= (cmd == fblr_pkg::CMD_READ) && rd_on;
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_fwd_src, clk, rst, (p_valid && fw_valid && fw_row == p_row) |-> ($past(mem_we) && $past(mem_waddr) == p_row))
  `ASSERT_ALWAYS(a_we_state, clk, rst, mem_we |-> (p_valid || state == fblr_pkg::ST_INIT || state == fblr_pkg::ST_CLEAR))
  `ASSERT_NEVER(a_px_idle, clk, rst, (state == fblr_pkg::ST_IDLE) && p_valid)
  `ASSERT_ALWAYS(a_reply, clk, rst, (state == fblr_pkg::ST_DONE && out_free) |=> res.valid)

endmodule

`default_nettype wire
